### sv/pc_pkg.sv
// Package for the path canonicalizer.
// Holds the character codes, command codes, scan phase and sequencer state types.
// No dependencies.
package pc_pkg;

  localparam int STORE_DEPTH_DEF = 1024;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_START,
    PH_INSIDE
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEQ,
    ST_DROP,
    ST_DROP_WAIT,
    ST_TRIM,
    ST_TRIM_WAIT,
    ST_TERM,
    ST_EMIT
  } state_t;

endpackage

### sv/path_canonicalizer.sv
// Path canonicalizer top level: normalized path kept in one synchronous store.
// Depends on pc_pkg.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid/in_ready, command, char, index | input
//  out     | out_valid/out_ready, result fields      | output
//
// One transaction in flight. Dot lookahead flushes write each held byte. A
// ".." walks back through the store one byte at a time (one store read port).
// End of path trims a trailing slash and writes a terminator. A read uses the
// registered store read port. The store has no reset; rst_n clears control
// only. A stalled out channel holds the block in its emit state.
module path_canonicalizer
  import pc_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_path_char,
  input  logic [9:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_length_result,
  output logic [7:0]  out_byte,
  output logic [10:0] out_norm_length,
  output logic        out_bad_start,
  output logic        out_overflow
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int PW = $clog2(STORE_DEPTH + 1);
  localparam int CW = (PW > 10) ? PW : 10;
  localparam logic [PW-1:0] LAST = PW'(STORE_DEPTH - 1);
  localparam logic [PW-1:0] ONE  = PW'(1);

  logic [7:0] mem [0:STORE_DEPTH-1];
  logic [7:0] rd_data_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [1:0] la_r, la_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic bad_r, bad_nxt, ovf_r, ovf_nxt;
  logic [2:0][7:0] put_q_r, put_q_nxt;
  logic [1:0] put_n_r, put_n_nxt;
  logic do_dec_r, do_dec_nxt, do_drop_r, do_drop_nxt, do_fin_r, do_fin_nxt;
  logic is_len_r, is_len_nxt, hit_r, hit_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_is_len_r, out_is_len_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic [10:0] out_len_r, out_len_nxt;
  logic out_bad_r, out_bad_nxt, out_ovf_r, out_ovf_nxt;

  // per-character plan
  logic [2:0][7:0] pl_q;
  logic [1:0] pl_n, la_eff;
  logic pl_dec, pl_drop, pl_fin, pl_new, pl_bad, pl_start;
  phase_t pl_phase;
  logic [1:0] pl_la;

  logic [PW-1:0] wp_m1;
  logic [CW-1:0] idx_ext, wp_ext;
  logic accept, emit_go;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign emit_go  = !out_valid_r || out_ready;
  assign wp_m1    = wp_r - ONE;
  assign idx_ext  = CW'(in_read_index);
  assign wp_ext   = CW'(wp_r);

  always_comb begin
    pl_q     = '0;
    pl_n     = 2'd0;
    pl_dec   = 1'b0;
    pl_drop  = 1'b0;
    pl_fin   = 1'b0;
    pl_new   = 1'b0;
    pl_bad   = 1'b0;
    pl_start = 1'b0;
    pl_phase = phase_r;
    pl_la    = la_r;
    la_eff   = la_r;
    unique case (phase_r)
      PH_FIRST: begin
        pl_new   = 1'b1;
        pl_q[0]  = CH_SLASH;
        pl_n     = 2'd1;
        la_eff   = 2'd0;
        pl_la    = 2'd0;
        pl_phase = PH_START;
        if (in_path_char != CH_SLASH) begin
          pl_bad   = 1'b1;
          pl_start = 1'b1;
        end
      end
      PH_START: pl_start = 1'b1;
      default: begin
        if (in_path_char == CH_NUL) begin
          pl_fin = 1'b1;
        end else begin
          pl_q[0] = in_path_char;
          pl_n    = 2'd1;
          if (in_path_char == CH_SLASH) pl_phase = PH_START;
        end
      end
    endcase
    if (pl_start) begin
      unique case (la_eff)
        2'd0: begin
          if (in_path_char == CH_SLASH) begin
          end else if (in_path_char == CH_NUL) begin
            pl_fin = 1'b1;
          end else if (in_path_char == CH_DOT) begin
            pl_la = 2'd1;
          end else begin
            pl_q[pl_n] = in_path_char;
            pl_n       = pl_n + 2'd1;
            pl_phase   = PH_INSIDE;
          end
        end
        2'd1: begin
          if (in_path_char == CH_SLASH) begin
            pl_la = 2'd0;
          end else if (in_path_char == CH_NUL) begin
            pl_dec = 1'b1;
            pl_fin = 1'b1;
          end else if (in_path_char == CH_DOT) begin
            pl_la = 2'd2;
          end else begin
            pl_q[0]  = CH_DOT;
            pl_q[1]  = in_path_char;
            pl_n     = 2'd2;
            pl_la    = 2'd0;
            pl_phase = PH_INSIDE;
          end
        end
        default: begin
          if (in_path_char == CH_SLASH) begin
            pl_drop = 1'b1;
            pl_la   = 2'd0;
          end else if (in_path_char == CH_NUL) begin
            pl_drop = 1'b1;
            pl_fin  = 1'b1;
          end else begin
            pl_q[0]  = CH_DOT;
            pl_q[1]  = CH_DOT;
            pl_q[2]  = in_path_char;
            pl_n     = 2'd3;
            pl_la    = 2'd0;
            pl_phase = PH_INSIDE;
          end
        end
      endcase
    end
    if (pl_fin) begin
      pl_phase = PH_FIRST;
      pl_la    = 2'd0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = (in_command == CMD_READ) ? ST_EMIT : ST_SEQ;
      end
      ST_SEQ: begin
        if (put_n_r != 2'd0 || do_dec_r) state_nxt = ST_SEQ;
        else if (do_drop_r)              state_nxt = ST_DROP;
        else if (do_fin_r)               state_nxt = ST_TRIM;
        else                             state_nxt = ST_IDLE;
      end
      ST_DROP:      state_nxt = (wp_r == '0) ? ST_SEQ : ST_DROP_WAIT;
      ST_DROP_WAIT: state_nxt = (rd_data_r == CH_SLASH) ? ST_SEQ : ST_DROP;
      ST_TRIM:      state_nxt = (wp_r > ONE) ? ST_TRIM_WAIT : ST_TERM;
      ST_TRIM_WAIT: state_nxt = ST_TERM;
      ST_TERM:      state_nxt = ST_EMIT;
      ST_EMIT:      if (emit_go) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = wp_r[AW-1:0];
    mem_raddr      = wp_m1[AW-1:0];
    mem_wdata      = put_q_r[0];
    phase_nxt      = phase_r;
    la_nxt         = la_r;
    wp_nxt         = wp_r;
    bad_nxt        = bad_r;
    ovf_nxt        = ovf_r;
    put_q_nxt      = put_q_r;
    put_n_nxt      = put_n_r;
    do_dec_nxt     = do_dec_r;
    do_drop_nxt    = do_drop_r;
    do_fin_nxt     = do_fin_r;
    is_len_nxt     = is_len_r;
    hit_nxt        = hit_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_is_len_nxt = out_is_len_r;
    out_byte_nxt   = out_byte_r;
    out_len_nxt    = out_len_r;
    out_bad_nxt    = out_bad_r;
    out_ovf_nxt    = out_ovf_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_READ) begin
            mem_re     = 1'b1;
            mem_raddr  = idx_ext[AW-1:0];
            hit_nxt    = idx_ext < wp_ext;
            is_len_nxt = 1'b0;
          end else begin
            put_q_nxt   = pl_q;
            put_n_nxt   = pl_n;
            do_dec_nxt  = pl_dec;
            do_drop_nxt = pl_drop;
            do_fin_nxt  = pl_fin;
            phase_nxt   = pl_phase;
            la_nxt      = pl_la;
            if (pl_new) begin
              wp_nxt  = '0;
              bad_nxt = pl_bad;
              ovf_nxt = 1'b0;
            end
          end
        end
      end
      ST_SEQ: begin
        if (put_n_r != 2'd0) begin
          if (wp_r < LAST) begin
            mem_we = 1'b1;
            wp_nxt = wp_r + ONE;
          end else begin
            ovf_nxt = 1'b1;
          end
          put_q_nxt = {8'h00, put_q_r[2:1]};
          put_n_nxt = put_n_r - 2'd1;
        end else if (do_dec_r) begin
          if (wp_r > ONE) wp_nxt = wp_m1;
          do_dec_nxt = 1'b0;
        end else if (do_drop_r) begin
          if (wp_r != '0) wp_nxt = wp_m1;
          do_drop_nxt = 1'b0;
        end
      end
      ST_DROP: begin
        if (wp_r == '0) begin
          wp_nxt = ONE;
        end else begin
          mem_re = 1'b1;
          wp_nxt = wp_m1;
        end
      end
      ST_DROP_WAIT: begin
        if (rd_data_r == CH_SLASH) wp_nxt = wp_r + ONE;
      end
      ST_TRIM: begin
        if (wp_r > ONE) mem_re = 1'b1;
      end
      ST_TRIM_WAIT: begin
        if (rd_data_r == CH_SLASH) wp_nxt = wp_m1;
      end
      ST_TERM: begin
        mem_we     = 1'b1;
        mem_wdata  = CH_NUL;
        wp_nxt     = wp_r + ONE;
        do_fin_nxt = 1'b0;
        is_len_nxt = 1'b1;
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt  = 1'b1;
          out_is_len_nxt = is_len_r;
          out_byte_nxt   = (!is_len_r && hit_r) ? rd_data_r : 8'h00;
          out_len_nxt    = is_len_r ? 11'(wp_r) : 11'd0;
          out_bad_nxt    = is_len_r && bad_r;
          out_ovf_nxt    = is_len_r && ovf_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_FIRST;
      la_r        <= 2'd0;
      wp_r        <= '0;
      bad_r       <= 1'b0;
      ovf_r       <= 1'b0;
      put_n_r     <= 2'd0;
      do_dec_r    <= 1'b0;
      do_drop_r   <= 1'b0;
      do_fin_r    <= 1'b0;
      is_len_r    <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      la_r        <= la_nxt;
      wp_r        <= wp_nxt;
      bad_r       <= bad_nxt;
      ovf_r       <= ovf_nxt;
      put_n_r     <= put_n_nxt;
      do_dec_r    <= do_dec_nxt;
      do_drop_r   <= do_drop_nxt;
      do_fin_r    <= do_fin_nxt;
      is_len_r    <= is_len_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    put_q_r      <= put_q_nxt;
    out_is_len_r <= out_is_len_nxt;
    out_byte_r   <= out_byte_nxt;
    out_len_r    <= out_len_nxt;
    out_bad_r    <= out_bad_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_is_length_result = out_is_len_r;
  assign out_byte             = out_byte_r;
  assign out_norm_length      = out_len_r;
  assign out_bad_start        = out_bad_r;
  assign out_overflow         = out_ovf_r;

endmodule
